/* rtl/core/cau_pkg.sv */
// cau_pkg: shared widths, mode codes, operation classes and queue item type
// for the complex arithmetic unit. No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 16;
    localparam int PROD_W        = 2 * DATA_W;
    localparam int VAL_W         = PROD_W + 2;
    localparam int QUO_W         = DATA_W + 2;
    localparam int REM_W         = PROD_W + QUO_W;

    localparam logic [2:0] MODE_ADD  = 3'd0;
    localparam logic [2:0] MODE_SUB  = 3'd1;
    localparam logic [2:0] MODE_MUL  = 3'd2;
    localparam logic [2:0] MODE_DIV  = 3'd3;
    localparam logic [2:0] MODE_CONJ = 3'd4;
    localparam logic [2:0] MODE_NEG  = 3'd5;
    localparam logic [2:0] MODE_MAG  = 3'd6;

    typedef enum logic [2:0] {
        CLS_ADD,
        CLS_SUB,
        CLS_MUL,
        CLS_DIV,
        CLS_CONJ,
        CLS_NEG,
        CLS_MAG,
        CLS_NONE
    } cls_t;

    typedef struct packed {
        cls_t                      cls;
        logic signed [DATA_W-1:0]  ar;
        logic signed [DATA_W-1:0]  ai;
        logic signed [DATA_W-1:0]  br;
        logic signed [DATA_W-1:0]  bi;
    } item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

endpackage

/* rtl/core/cau_front.sv */
// cau_front: input register and mode decode for the complex arithmetic unit.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         mode,
    input  logic signed [cau_pkg::DATA_W-1:0]  a_re,
    input  logic signed [cau_pkg::DATA_W-1:0]  a_im,
    input  logic signed [cau_pkg::DATA_W-1:0]  b_re,
    input  logic signed [cau_pkg::DATA_W-1:0]  b_im,
    input  cau_pkg::qstat_t                    q_stat,
    output logic                               push,
    output cau_pkg::item_t                     item
);

    logic           valid_reg;
    logic           valid_next;
    cau_pkg::item_t item_reg;
    cau_pkg::item_t item_next;
    logic           accept;

    assign busy   = valid_reg && q_stat.full;
    assign push   = valid_reg && !q_stat.full;
    assign accept = start && !busy;
    assign item   = item_reg;

    always_comb
    begin
        item_next.ar  = a_re;
        item_next.ai  = a_im;
        item_next.br  = b_re;
        item_next.bi  = b_im;
        item_next.cls = cau_pkg::CLS_NONE;
        case (mode)
            cau_pkg::MODE_ADD:  item_next.cls = cau_pkg::CLS_ADD;
            cau_pkg::MODE_SUB:  item_next.cls = cau_pkg::CLS_SUB;
            cau_pkg::MODE_MUL:  item_next.cls = cau_pkg::CLS_MUL;
            cau_pkg::MODE_DIV:  item_next.cls = cau_pkg::CLS_DIV;
            cau_pkg::MODE_CONJ: item_next.cls = cau_pkg::CLS_CONJ;
            cau_pkg::MODE_NEG:  item_next.cls = cau_pkg::CLS_NEG;
            cau_pkg::MODE_MAG:
            begin
                // magnitude squared of a: route a into the b multiplier inputs
                item_next.cls = cau_pkg::CLS_MAG;
                item_next.br  = a_re;
                item_next.bi  = a_im;
            end
            default:            item_next.cls = cau_pkg::CLS_NONE;
        endcase
    end

    always_comb
    begin
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= item_next;
        end
    end

endmodule

/* rtl/core/cau_queue.sv */
// cau_queue: two-entry queue of decoded beats between front and back.
// Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  cau_pkg::item_t  item_in,
    output cau_pkg::qstat_t q_stat,
    output logic            pop,
    output cau_pkg::item_t  item_out
);

    localparam int DEPTH = 2;
    localparam int PTR_W = 1;

    cau_pkg::item_t   mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   cnt_reg;
    logic [PTR_W:0]   cnt_next;

    assign q_stat.empty = (cnt_reg == '0);
    assign q_stat.full  = (cnt_reg == (PTR_W+1)'(DEPTH));
    assign pop          = !q_stat.empty;
    assign item_out     = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        cnt_next    = cnt_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

/* rtl/core/cau_back.sv */
// cau_back: execution pipeline: products, sums, restoring divider stages and
// saturation. Depends on cau_pkg.
`timescale 1ns / 1ps

module cau_back #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  cau_pkg::item_t                     item,
    output logic                               done,
    output logic signed [cau_pkg::DATA_W-1:0]  res_re,
    output logic signed [cau_pkg::DATA_W-1:0]  res_im,
    output logic                               overflow,
    output logic                               div_zero
);

    localparam int DW = cau_pkg::DATA_W;
    localparam int PW = cau_pkg::PROD_W;
    localparam int VW = cau_pkg::VAL_W;
    localparam int QW = cau_pkg::QUO_W;
    localparam int RW = cau_pkg::REM_W;

    localparam logic signed [VW-1:0] SAT_MAX = (VW'(1) <<< (DW - 1)) - VW'(1);
    localparam logic signed [VW-1:0] SAT_MIN = -(VW'(1) <<< (DW - 1));

    typedef struct packed {
        logic                  valid;
        cau_pkg::cls_t         cls;
        logic signed [PW-1:0]  p_rr;
        logic signed [PW-1:0]  p_ii;
        logic signed [PW-1:0]  p_ri;
        logic signed [PW-1:0]  p_ir;
        logic signed [PW-1:0]  p_br2;
        logic signed [PW-1:0]  p_bi2;
        logic signed [VW-1:0]  lin_re;
        logic signed [VW-1:0]  lin_im;
    } s1_t;

    typedef struct packed {
        logic                  valid;
        logic                  is_div;
        logic                  dz;
        logic signed [VW-1:0]  val_re;
        logic signed [VW-1:0]  val_im;
        logic                  neg_re;
        logic                  neg_im;
        logic [PW-1:0]         num_re;
        logic [PW-1:0]         num_im;
        logic [PW-1:0]         den;
    } s2_t;

    typedef struct packed {
        logic                  valid;
        logic                  is_div;
        logic                  dz;
        logic signed [VW-1:0]  val_re;
        logic signed [VW-1:0]  val_im;
        logic                  neg_re;
        logic                  neg_im;
        logic                  ovf_re;
        logic                  ovf_im;
        logic [RW-1:0]         rem_re;
        logic [RW-1:0]         rem_im;
        logic [QW-1:0]         q_re;
        logic [QW-1:0]         q_im;
        logic [PW-1:0]         den;
    } ds_t;

    s1_t s1_reg, s1_next;
    s2_t s2_reg, s2_next;
    ds_t dst_reg  [QW+1];
    ds_t dst_next [QW+1];

    logic                  done_reg;
    logic signed [DW-1:0]  res_re_reg;
    logic signed [DW-1:0]  res_im_reg;
    logic                  ovf_reg;
    logic                  dz_reg;
    logic                  done_next;
    logic signed [DW-1:0]  res_re_next;
    logic signed [DW-1:0]  res_im_next;
    logic                  ovf_next;
    logic                  dz_next;

    // stage 1: products and linear results
    always_comb
    begin
        logic signed [VW-1:0] ar_w;
        logic signed [VW-1:0] ai_w;
        logic signed [VW-1:0] br_w;
        logic signed [VW-1:0] bi_w;
        ar_w = VW'(item.ar);
        ai_w = VW'(item.ai);
        br_w = VW'(item.br);
        bi_w = VW'(item.bi);
        s1_next.valid = in_valid;
        s1_next.cls   = item.cls;
        s1_next.p_rr  = item.ar * item.br;
        s1_next.p_ii  = item.ai * item.bi;
        s1_next.p_ri  = item.ar * item.bi;
        s1_next.p_ir  = item.ai * item.br;
        s1_next.p_br2 = item.br * item.br;
        s1_next.p_bi2 = item.bi * item.bi;
        case (item.cls)
            cau_pkg::CLS_ADD:
            begin
                s1_next.lin_re = ar_w + br_w;
                s1_next.lin_im = ai_w + bi_w;
            end
            cau_pkg::CLS_SUB:
            begin
                s1_next.lin_re = ar_w - br_w;
                s1_next.lin_im = ai_w - bi_w;
            end
            cau_pkg::CLS_CONJ:
            begin
                s1_next.lin_re = ar_w;
                s1_next.lin_im = -ai_w;
            end
            cau_pkg::CLS_NEG:
            begin
                s1_next.lin_re = -ar_w;
                s1_next.lin_im = -ai_w;
            end
            default:
            begin
                s1_next.lin_re = '0;
                s1_next.lin_im = '0;
            end
        endcase
    end

    // stage 2: sums of products, scaling, divider operands
    always_comb
    begin
        logic signed [VW-1:0] e_rr;
        logic signed [VW-1:0] e_ii;
        logic signed [VW-1:0] e_ri;
        logic signed [VW-1:0] e_ir;
        logic signed [VW-1:0] n_re;
        logic signed [VW-1:0] n_im;
        logic [PW-1:0]        den;
        e_rr = VW'(s1_reg.p_rr);
        e_ii = VW'(s1_reg.p_ii);
        e_ri = VW'(s1_reg.p_ri);
        e_ir = VW'(s1_reg.p_ir);
        n_re = e_rr + e_ii;
        n_im = e_ir - e_ri;
        den  = PW'(s1_reg.p_br2) + PW'(s1_reg.p_bi2);
        s2_next.valid  = s1_reg.valid;
        s2_next.is_div = 1'b0;
        s2_next.dz     = 1'b0;
        s2_next.val_re = '0;
        s2_next.val_im = '0;
        s2_next.neg_re = n_re < 0;
        s2_next.neg_im = n_im < 0;
        s2_next.num_re = PW'((n_re < 0) ? -n_re : n_re);
        s2_next.num_im = PW'((n_im < 0) ? -n_im : n_im);
        s2_next.den    = den;
        case (s1_reg.cls)
            cau_pkg::CLS_ADD, cau_pkg::CLS_SUB, cau_pkg::CLS_CONJ, cau_pkg::CLS_NEG:
            begin
                s2_next.val_re = s1_reg.lin_re;
                s2_next.val_im = s1_reg.lin_im;
            end
            cau_pkg::CLS_MUL:
            begin
                s2_next.val_re = (e_rr - e_ii) >>> FRAC_BITS;
                s2_next.val_im = (e_ri + e_ir) >>> FRAC_BITS;
            end
            cau_pkg::CLS_MAG:
            begin
                s2_next.val_re = n_re >>> FRAC_BITS;
            end
            cau_pkg::CLS_DIV:
            begin
                s2_next.dz     = (den == '0);
                s2_next.is_div = (den != '0);
            end
            default:
            begin
                s2_next.val_re = '0;
            end
        endcase
    end

    // divider entry: quotient range check and shifted numerators
    always_comb
    begin
        logic [RW-1:0] den_top;
        logic [RW-1:0] sh_re;
        logic [RW-1:0] sh_im;
        den_top = RW'(s2_reg.den) << QW;
        sh_re   = RW'(s2_reg.num_re) << FRAC_BITS;
        sh_im   = RW'(s2_reg.num_im) << FRAC_BITS;
        dst_next[0].valid  = s2_reg.valid;
        dst_next[0].is_div = s2_reg.is_div;
        dst_next[0].dz     = s2_reg.dz;
        dst_next[0].val_re = s2_reg.val_re;
        dst_next[0].val_im = s2_reg.val_im;
        dst_next[0].neg_re = s2_reg.neg_re;
        dst_next[0].neg_im = s2_reg.neg_im;
        dst_next[0].ovf_re = sh_re >= den_top;
        dst_next[0].ovf_im = sh_im >= den_top;
        dst_next[0].rem_re = sh_re;
        dst_next[0].rem_im = sh_im;
        dst_next[0].q_re   = '0;
        dst_next[0].q_im   = '0;
        dst_next[0].den    = s2_reg.den;
    end

    // one quotient bit per stage, MSB first
    for (genvar k = 0; k < QW; k++)
    begin : g_div
        localparam int BIT = QW - 1 - k;
        always_comb
        begin
            logic [RW-1:0] trial;
            trial         = RW'(dst_reg[k].den) << BIT;
            dst_next[k+1] = dst_reg[k];
            if (dst_reg[k].rem_re >= trial)
            begin
                dst_next[k+1].rem_re    = dst_reg[k].rem_re - trial;
                dst_next[k+1].q_re[BIT] = 1'b1;
            end
            if (dst_reg[k].rem_im >= trial)
            begin
                dst_next[k+1].rem_im    = dst_reg[k].rem_im - trial;
                dst_next[k+1].q_im[BIT] = 1'b1;
            end
        end
    end

    for (genvar k = 0; k <= QW; k++)
    begin : g_dreg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dst_reg[k] <= '0;
            end
            else
            begin
                dst_reg[k] <= dst_next[k];
            end
        end
    end

    // final: signed quotient and 32-bit saturation
    always_comb
    begin
        logic [QW-1:0]        mag_re;
        logic [QW-1:0]        mag_im;
        logic signed [VW-1:0] t_re;
        logic signed [VW-1:0] t_im;
        logic signed [VW-1:0] f_re;
        logic signed [VW-1:0] f_im;
        logic                 o_re;
        logic                 o_im;
        mag_re = dst_reg[QW].ovf_re ? (QW'(1) << (QW - 1)) : dst_reg[QW].q_re;
        mag_im = dst_reg[QW].ovf_im ? (QW'(1) << (QW - 1)) : dst_reg[QW].q_im;
        t_re   = VW'(mag_re);
        t_im   = VW'(mag_im);
        if (dst_reg[QW].is_div)
        begin
            f_re = dst_reg[QW].neg_re ? -t_re : t_re;
            f_im = dst_reg[QW].neg_im ? -t_im : t_im;
        end
        else
        begin
            f_re = dst_reg[QW].val_re;
            f_im = dst_reg[QW].val_im;
        end
        o_re = (f_re > SAT_MAX) || (f_re < SAT_MIN);
        o_im = (f_im > SAT_MAX) || (f_im < SAT_MIN);
        res_re_next = (f_re > SAT_MAX) ? DW'(SAT_MAX) :
                      (f_re < SAT_MIN) ? DW'(SAT_MIN) : DW'(f_re);
        res_im_next = (f_im > SAT_MAX) ? DW'(SAT_MAX) :
                      (f_im < SAT_MIN) ? DW'(SAT_MIN) : DW'(f_im);
        ovf_next  = o_re || o_im;
        dz_next   = dst_reg[QW].dz;
        done_next = dst_reg[QW].valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            s2_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= s1_next;
            s2_reg   <= s2_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_re_reg <= res_re_next;
        res_im_reg <= res_im_next;
        ovf_reg    <= ovf_next;
        dz_reg     <= dz_next;
    end

    assign done     = done_reg;
    assign res_re   = res_re_reg;
    assign res_im   = res_im_reg;
    assign overflow = ovf_reg;
    assign div_zero = dz_reg;

endmodule

/* rtl/core/complex_arith_unit.sv */
// complex_arith_unit: top level of the complex fixed-point ALU.
// Depends on cau_pkg, cau_front, cau_queue, cau_back.
`timescale 1ns / 1ps

// Usage:
//   Drive mode, a_re, a_im, b_re, b_im and raise start; the beat is taken at
//   a rising edge where start is high and busy is low.
//   Each beat yields one result on res_re, res_im, overflow and div_zero,
//   shown for one cycle with done high. Results leave in order.
//   Path: 1 input register, 1 queue, 2 product/sum stages, 1 range
//   check, 34 divider stages, 1 saturate/output register, in that order.
//   Throughput: one beat per cycle; every mode runs the same pipeline and
//   the divider retires one quotient bit per stage.
//   busy only rises if the queue fills, which the back end prevents since
//   it drains one beat every cycle.
//   Reset (rst_n low, asynchronous) empties the queue and the pipeline;
//   beats in flight are dropped.
//   The receiver cannot stall: a result is gone after its done cycle.
module complex_arith_unit #(
    parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [2:0]                         mode,
    input  logic signed [cau_pkg::DATA_W-1:0]  a_re,
    input  logic signed [cau_pkg::DATA_W-1:0]  a_im,
    input  logic signed [cau_pkg::DATA_W-1:0]  b_re,
    input  logic signed [cau_pkg::DATA_W-1:0]  b_im,
    output logic                               done,
    output logic signed [cau_pkg::DATA_W-1:0]  res_re,
    output logic signed [cau_pkg::DATA_W-1:0]  res_im,
    output logic                               overflow,
    output logic                               div_zero
);

    cau_pkg::qstat_t q_stat;
    cau_pkg::item_t  f_item;
    cau_pkg::item_t  q_item;
    logic            push;
    logic            pop;

    cau_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .mode   (mode),
        .a_re   (a_re),
        .a_im   (a_im),
        .b_re   (b_re),
        .b_im   (b_im),
        .q_stat (q_stat),
        .push   (push),
        .item   (f_item)
    );

    cau_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (f_item),
        .q_stat   (q_stat),
        .pop      (pop),
        .item_out (q_item)
    );

    cau_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pop),
        .item     (q_item),
        .done     (done),
        .res_re   (res_re),
        .res_im   (res_im),
        .overflow (overflow),
        .div_zero (div_zero)
    );

    a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && div_zero |-> res_re == '0 && res_im == '0 && !overflow)
        else $error("div_zero result not cleared");

    a_ovf_sat: assert property (@(posedge clk) disable iff (!rst_n)
        done && overflow && res_re != 32'sh7FFFFFFF && res_re != 32'sh80000000
        |-> res_im == 32'sh7FFFFFFF || res_im == 32'sh80000000)
        else $error("overflow without a saturated part");

    a_busy_full: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> q_stat.full)
        else $error("busy without a full queue");

endmodule
